// File: sv/rne_pkg.sv
// Shared types, constants and letter tables for the Roman numeral encoder.
`default_nettype none

package rne_pkg;

   localparam int VALUE_W   = 13;
   localparam int LETTER_W  = 8;
   localparam int RUN_SLOTS = 16;
   localparam int LEN_W     = $clog2(RUN_SLOTS + 1);

   localparam int THOUSAND  = 1000;
   localparam int HUNDRED   = 100;
   localparam int TEN       = 10;
   localparam int MAX_VALID = 4999;

   // Numeral symbol codes; NONE marks an empty slot or the error result
   typedef enum logic [2:0] {
      SYM_NONE = 3'd0,
      SYM_I    = 3'd1,
      SYM_V    = 3'd2,
      SYM_X    = 3'd3,
      SYM_L    = 3'd4,
      SYM_C    = 3'd5,
      SYM_D    = 3'd6,
      SYM_M    = 3'd7
   } sym_type;

   // Decimal digits of one item, plus its range error
   typedef struct packed {
      logic       err;
      logic [2:0] thou;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   // Letter pattern of one decimal place
   typedef struct packed {
      logic [2:0]        len;
      sym_type [3:0]     code;
   } pat_type;

   // Complete letter run of one item, slot 0 first
   typedef struct packed {
      logic                      err;
      logic [LEN_W-1:0]          len;
      sym_type [RUN_SLOTS-1:0]   code;
   } run_type;

   // Subtractive pattern of one digit over the one, five and ten letters
   function automatic pat_type digit_pat(input logic [3:0] d, input sym_type one,
                                         input sym_type five, input sym_type ten);
      pat_type p;
      p.len  = 3'd0;
      for (int i = 0; i < 4; i++) begin
         p.code[i] = SYM_NONE;
      end
      case (d)
         4'd1: begin
            p.len = 3'd1; p.code[0] = one;
         end
         4'd2: begin
            p.len = 3'd2; p.code[0] = one; p.code[1] = one;
         end
         4'd3: begin
            p.len = 3'd3; p.code[0] = one; p.code[1] = one; p.code[2] = one;
         end
         4'd4: begin
            p.len = 3'd2; p.code[0] = one; p.code[1] = five;
         end
         4'd5: begin
            p.len = 3'd1; p.code[0] = five;
         end
         4'd6: begin
            p.len = 3'd2; p.code[0] = five; p.code[1] = one;
         end
         4'd7: begin
            p.len = 3'd3; p.code[0] = five; p.code[1] = one; p.code[2] = one;
         end
         4'd8: begin
            p.len = 3'd4; p.code[0] = five; p.code[1] = one; p.code[2] = one;
            p.code[3] = one;
         end
         4'd9: begin
            p.len = 3'd2; p.code[0] = one; p.code[1] = ten;
         end
         default: begin
            p.len = 3'd0;
         end
      endcase
      return p;
   endfunction

   // ASCII code of a symbol; zero for an empty slot
   function automatic logic [LETTER_W-1:0] sym_ascii(input sym_type s);
      logic [LETTER_W-1:0] a;
      case (s)
         SYM_I:   a = 8'h49;
         SYM_V:   a = 8'h56;
         SYM_X:   a = 8'h58;
         SYM_L:   a = 8'h4C;
         SYM_C:   a = 8'h43;
         SYM_D:   a = 8'h44;
         SYM_M:   a = 8'h4D;
         default: a = 8'h00;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// File: sv/rne_digit_split.sv
// Four-stage pipeline that splits the binary value into decimal digits.
`default_nettype none

module rne_digit_split (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire  [rne_pkg::VALUE_W-1:0]      in_value,
   output logic                             out_valid,
   input  wire                              out_ready,
   output rne_pkg::digits_type              out_digits
);
   import rne_pkg::*;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 v1_in, v2_in, v3_in, v4_in;
   logic                 r1, r2, r3, r4;

   logic [VALUE_W-1:0]   value_ff;
   logic                 err2_ff, err3_ff, err4_ff;
   logic [2:0]           thou2_ff, thou3_ff, thou4_ff;
   logic [9:0]           rem2_ff;
   logic [3:0]           hund3_ff, hund4_ff;
   logic [6:0]           rem3_ff;
   logic [3:0]           tens4_ff, units4_ff;

   logic                 err2_in;
   logic [2:0]           thou2_in;
   logic [9:0]           rem2_in;
   logic [3:0]           hund3_in;
   logic [6:0]           rem3_in;
   logic [3:0]           tens4_in, units4_in;

   // Stall chain: a stage takes new data when empty or when it moves on
   always_comb begin
      r4 = !v4_ff || out_ready;
      r3 = !v3_ff || r4;
      r2 = !v2_ff || r3;
      r1 = !v1_ff || r2;
   end

   assign in_ready = r1;

   always_comb begin
      v1_in = r1 ? in_valid : v1_ff;
      v2_in = r2 ? v1_ff    : v2_ff;
      v3_in = r3 ? v2_ff    : v3_ff;
      v4_in = r4 ? v3_ff    : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Check range and strip the thousands
   always_comb begin
      err2_in  = (value_ff == '0) || (value_ff > VALUE_W'(MAX_VALID));
      thou2_in = 3'd0;
      rem2_in  = value_ff[9:0];
      for (int i = 1; i <= 4; i++) begin
         if (value_ff >= VALUE_W'(i * THOUSAND)) begin
            thou2_in = 3'(i);
            rem2_in  = 10'(value_ff - VALUE_W'(i * THOUSAND));
         end
      end
   end

   // Strip the hundreds
   always_comb begin
      hund3_in = 4'd0;
      rem3_in  = rem2_ff[6:0];
      for (int i = 1; i <= 9; i++) begin
         if (rem2_ff >= 10'(i * HUNDRED)) begin
            hund3_in = 4'(i);
            rem3_in  = 7'(rem2_ff - 10'(i * HUNDRED));
         end
      end
   end

   // Split tens and units
   always_comb begin
      tens4_in  = 4'd0;
      units4_in = rem3_ff[3:0];
      for (int i = 1; i <= 9; i++) begin
         if (rem3_ff >= 7'(i * TEN)) begin
            tens4_in  = 4'(i);
            units4_in = 4'(rem3_ff - 7'(i * TEN));
         end
      end
   end

   // Advance payload alongside the valid bits
   always_ff @(posedge clock) begin
      if (r1 && in_valid) begin
         value_ff <= in_value;
      end
      if (r2 && v1_ff) begin
         err2_ff  <= err2_in;
         thou2_ff <= thou2_in;
         rem2_ff  <= rem2_in;
      end
      if (r3 && v2_ff) begin
         err3_ff  <= err2_ff;
         thou3_ff <= thou2_ff;
         hund3_ff <= hund3_in;
         rem3_ff  <= rem3_in;
      end
      if (r4 && v3_ff) begin
         err4_ff   <= err3_ff;
         thou4_ff  <= thou3_ff;
         hund4_ff  <= hund3_ff;
         tens4_ff  <= tens4_in;
         units4_ff <= units4_in;
      end
   end

   assign out_valid        = v4_ff;
   assign out_digits.err   = err4_ff;
   assign out_digits.thou  = thou4_ff;
   assign out_digits.hund  = hund4_ff;
   assign out_digits.tens  = tens4_ff;
   assign out_digits.units = units4_ff;

endmodule

`default_nettype wire

// File: sv/rne_run_build.sv
// Two-stage pipeline that turns decimal digits into a packed letter run.
`default_nettype none

module rne_run_build (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  rne_pkg::digits_type     in_digits,
   output logic                    out_valid,
   input  wire                     out_ready,
   output rne_pkg::run_type        out_run
);
   import rne_pkg::*;

   logic             v5_ff, v6_ff, v5_in, v6_in, r5, r6;

   logic             err5_ff;
   logic [2:0]       lt5_ff;
   pat_type          ph5_ff, px5_ff, pu5_ff;
   logic [LEN_W-1:0] o2_5_ff, o3_5_ff, o4_5_ff;

   pat_type          ph_in, px_in, pu_in;
   logic [LEN_W-1:0] o2_in, o3_in, o4_in;

   run_type          run6_ff, run6_in;

   always_comb begin
      r6 = !v6_ff || out_ready;
      r5 = !v5_ff || r6;
   end

   assign in_ready = r5;

   always_comb begin
      v5_in = r5 ? in_valid : v5_ff;
      v6_in = r6 ? v5_ff    : v6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   // Look up each place's pattern and the running end offsets
   always_comb begin
      ph_in = digit_pat(in_digits.hund,  SYM_C, SYM_D, SYM_M);
      px_in = digit_pat(in_digits.tens,  SYM_X, SYM_L, SYM_C);
      pu_in = digit_pat(in_digits.units, SYM_I, SYM_V, SYM_X);
      o2_in = LEN_W'(in_digits.thou) + LEN_W'(ph_in.len);
      o3_in = o2_in + LEN_W'(px_in.len);
      o4_in = o3_in + LEN_W'(pu_in.len);
   end

   // Place every slot from the segment it falls in
   always_comb begin
      logic [LEN_W-1:0] k;
      logic [LEN_W-1:0] o1;
      o1          = LEN_W'(lt5_ff);
      run6_in.err = err5_ff;
      run6_in.len = err5_ff ? LEN_W'(1) : o4_5_ff;
      for (int s = 0; s < RUN_SLOTS; s++) begin
         k = LEN_W'(s);
         if (err5_ff) begin
            run6_in.code[s] = SYM_NONE;
         end else if (k < o1) begin
            run6_in.code[s] = SYM_M;
         end else if (k < o2_5_ff) begin
            run6_in.code[s] = ph5_ff.code[2'(k - o1)];
         end else if (k < o3_5_ff) begin
            run6_in.code[s] = px5_ff.code[2'(k - o2_5_ff)];
         end else if (k < o4_5_ff) begin
            run6_in.code[s] = pu5_ff.code[2'(k - o3_5_ff)];
         end else begin
            run6_in.code[s] = SYM_NONE;
         end
      end
   end

   // Advance payload alongside the valid bits
   always_ff @(posedge clock) begin
      if (r5 && in_valid) begin
         err5_ff <= in_digits.err;
         lt5_ff  <= in_digits.thou;
         ph5_ff  <= ph_in;
         px5_ff  <= px_in;
         pu5_ff  <= pu_in;
         o2_5_ff <= o2_in;
         o3_5_ff <= o3_in;
         o4_5_ff <= o4_in;
      end
      if (r6 && v5_ff) begin
         run6_ff <= run6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_run   = run6_ff;

endmodule

`default_nettype wire

// File: sv/rne_emitter.sv
// Serialiser that sends one letter of the current run per cycle.
`default_nettype none

module rne_emitter (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  rne_pkg::run_type                  in_run,
   output logic                              rsp_strobe,
   output logic [rne_pkg::LETTER_W-1:0]      rsp_letter,
   output logic                              rsp_last,
   output logic                              rsp_error
);
   import rne_pkg::*;

   logic [LEN_W-1:0]          cnt_ff, cnt_in;
   sym_type [RUN_SLOTS-1:0]   code_ff, code_in;
   logic                      err_ff;
   logic                      go, load;

   logic                      strobe_ff, strobe_in;
   logic [LETTER_W-1:0]       letter_ff, letter_in;
   logic                      last_ff, last_in;
   logic                      error_ff;

   // Take the next run while the final letter of this one goes out
   assign go       = (cnt_ff != '0);
   assign in_ready = (cnt_ff <= LEN_W'(1));
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         cnt_in  = in_run.len;
         code_in = in_run.code;
      end else if (go) begin
         cnt_in  = cnt_ff - LEN_W'(1);
         code_in = code_ff;
         for (int s = 0; s < RUN_SLOTS - 1; s++) begin
            code_in[s] = code_ff[s + 1];
         end
         code_in[RUN_SLOTS-1] = SYM_NONE;
      end else begin
         cnt_in  = cnt_ff;
         code_in = code_ff;
      end
   end

   // Form the next result from the head slot
   always_comb begin
      strobe_in = go;
      letter_in = err_ff ? '0 : sym_ascii(code_ff[0]);
      last_in   = (cnt_ff == LEN_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      error_ff  <= err_ff;
      if (load) begin
         err_ff <= in_run.err;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_letter = letter_ff;
   assign rsp_last   = last_ff;
   assign rsp_error  = error_ff;

endmodule

`default_nettype wire

// File: sv/binary_to_roman_numeral_encoder.sv
// Top level of the binary to Roman numeral encoder.
// The serialiser takes the next run while the final letter of the current one goes out.
// The longest run is 16 letters, for 4888; an error result is a single letter.
// Six pipeline stages feed a letter serialiser that sends one letter per cycle;
// busy rises when the serialiser holds a run with more than one letter left and every stage is full.
// Synchronous active-high reset empties every stage; results cannot be stalled.
`default_nettype none

module binary_to_roman_numeral_encoder (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire  [rne_pkg::VALUE_W-1:0]       req_value,
   output logic                              rsp_strobe,
   output logic [rne_pkg::LETTER_W-1:0]      rsp_letter,
   output logic                              rsp_last,
   output logic                              rsp_error
);
   import rne_pkg::*;

   logic        split_ready;
   logic        dig_valid, dig_ready;
   digits_type  digits;
   logic        run_valid, run_ready;
   run_type     run;

   assign busy = !split_ready;

   rne_digit_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_ready   (split_ready),
      .in_value   (req_value),
      .out_valid  (dig_valid),
      .out_ready  (dig_ready),
      .out_digits (digits)
   );

   rne_run_build u_build (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_ready  (dig_ready),
      .in_digits (digits),
      .out_valid (run_valid),
      .out_ready (run_ready),
      .out_run   (run)
   );

   rne_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (run_valid),
      .in_ready   (run_ready),
      .in_run     (run),
      .rsp_strobe (rsp_strobe),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule

`default_nettype wire

// File: sv/rne_checker.sv
// Port-level checker for the Roman numeral encoder, with its bind.
`default_nettype none

module rne_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              start,
   input wire                              busy,
   input wire [rne_pkg::VALUE_W-1:0]       req_value,
   input wire                              rsp_strobe,
   input wire [rne_pkg::LETTER_W-1:0]      rsp_letter,
   input wire                              rsp_last,
   input wire                              rsp_error
);

   // Reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock) reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // A transferred number carries known bits
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> !$isunknown(req_value))
      else $error("unknown value on input transfer");

   // An error result is a single zero letter
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error) |-> (rsp_last && rsp_letter == 8'h00))
      else $error("malformed error result");

   // Every normal result carries a numeral letter
   a_letter_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_error) |-> (rsp_letter == 8'h49 || rsp_letter == 8'h56 ||
         rsp_letter == 8'h58 || rsp_letter == 8'h4C || rsp_letter == 8'h43 ||
         rsp_letter == 8'h44 || rsp_letter == 8'h4D))
      else $error("result letter is not a numeral");

   // A run goes out without gaps until its last letter
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_strobe && !rsp_error))
      else $error("gap or error inside a letter run");

endmodule

bind binary_to_roman_numeral_encoder rne_checker u_rne_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_value  (req_value),
   .rsp_strobe (rsp_strobe),
   .rsp_letter (rsp_letter),
   .rsp_last   (rsp_last),
   .rsp_error  (rsp_error)
);

`default_nettype wire
